[src/ir_barrier_burst_monitor_assert.svh]
// ----------------------------------------------------------------------------
// ir_barrier_burst_monitor_assert.svh
// assertion macros used by the burst monitor core (irbbm_core)
// ----------------------------------------------------------------------------
`ifndef IR_BARRIER_BURST_MONITOR_ASSERT_SVH
`define IR_BARRIER_BURST_MONITOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IRBBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define IRBBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/irbbm_pkg.sv]
// ----------------------------------------------------------------------------
// irbbm_pkg
// types and constants of the infrared barrier burst monitor
// ----------------------------------------------------------------------------
`default_nettype none

package irbbm_pkg;

    localparam int unsigned BURST_PULSES_DEF = 8;
    localparam int unsigned BURST_W          = 7;
    localparam int unsigned PERIOD_W         = 10;
    localparam int unsigned BEEP_W           = 11;
    localparam int unsigned COUNT_W          = 16;

    localparam logic [PERIOD_W-1:0] SLOW_DIV_RESET = PERIOD_W'(64);
    localparam logic [PERIOD_W-1:0] SETUP_PERIOD   = PERIOD_W'(10);
    localparam logic [PERIOD_W-1:0] STARTED_PERIOD = PERIOD_W'(1);

    localparam logic OP_CARRIER = 1'b0;
    localparam logic OP_HOUSE   = 1'b1;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_SETUP   = 2'd1;
    localparam logic [1:0] MODE_STARTED = 2'd2;
    localparam logic [1:0] MODE_STOPPED = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [1:0] mode;
        logic       calibrating;
        logic       rx_level;
    } t_in_item;

    typedef struct packed {
        logic               ir_drive;
        logic               beep_out;
        logic               cal_indicator;
        logic [COUNT_W-1:0] loss_count;
    } t_out_item;

endpackage

`default_nettype wire

[src/irbbm_core.sv]
// ----------------------------------------------------------------------------
// irbbm_core
// burst timing, beam-loss detection and beep state, one beat per cycle while i_accept is high
// ----------------------------------------------------------------------------
`default_nettype none

module irbbm_core #(
    parameter int unsigned BURST_PULSES = irbbm_pkg::BURST_PULSES_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  irbbm_pkg::t_in_item                 i_item,
    input  wire                                 i_cfg_we,
    input  wire [irbbm_pkg::PERIOD_W-1:0]       i_cfg_data,
    output irbbm_pkg::t_out_item                o_result
);

    localparam int unsigned BW = irbbm_pkg::BURST_W;
    localparam int unsigned PW = irbbm_pkg::PERIOD_W;
    localparam int unsigned EW = irbbm_pkg::BEEP_W;
    localparam int unsigned CW = irbbm_pkg::COUNT_W;
    localparam logic [BW-1:0] BURST_LOAD = BW'(2 * BURST_PULSES);

    logic [PW-1:0] r_slow_div;
    logic [BW-1:0] r_burst_left, n_burst_left;
    logic          r_loss_pending, n_loss_pending;
    logic [PW-1:0] r_period_timer, n_period_timer;
    logic [EW-1:0] r_beep_left, n_beep_left;
    logic [CW-1:0] r_loss_counter, n_loss_counter;
    logic          r_drive_level, n_drive_level;
    logic          r_beep_level, n_beep_level;
    logic          r_led_level, n_led_level;

    logic [PW-1:0] period;
    logic [PW:0]   tick_sum;

    always_comb begin
        case (i_item.mode)
            irbbm_pkg::MODE_IDLE:    period = '0;
            irbbm_pkg::MODE_STARTED: period = irbbm_pkg::STARTED_PERIOD;
            irbbm_pkg::MODE_SETUP:   period = irbbm_pkg::SETUP_PERIOD;
            default: begin
                period = i_item.calibrating ? irbbm_pkg::SETUP_PERIOD : r_slow_div;
            end
        endcase
    end

    always_comb begin
        n_burst_left   = r_burst_left;
        n_loss_pending = r_loss_pending;
        n_period_timer = r_period_timer;
        n_beep_left    = r_beep_left;
        n_loss_counter = r_loss_counter;
        n_drive_level  = r_drive_level;
        n_beep_level   = r_beep_level;
        n_led_level    = r_led_level;
        tick_sum       = {1'b0, r_period_timer} + (PW+1)'(1);
        if (i_accept) begin
            if (i_item.operation == irbbm_pkg::OP_CARRIER) begin
                if (r_burst_left != '0) begin
                    n_burst_left  = r_burst_left - BW'(1);
                    n_drive_level = n_burst_left[0];
                    if (n_burst_left == '0 && i_item.rx_level) begin
                        n_loss_pending = 1'b1;
                    end
                end
            end else begin
                n_led_level = i_item.calibrating;
                if (r_loss_pending) begin
                    n_loss_pending = 1'b0;
                    n_loss_counter = r_loss_counter + CW'(1);
                    if (i_item.calibrating) begin
                        n_beep_left = {period, 1'b0};
                    end
                end
                if (n_beep_left != '0) begin
                    n_beep_left  = n_beep_left - EW'(1);
                    n_beep_level = 1'b1;
                end else begin
                    n_beep_level = 1'b0;
                end
                if (period != '0) begin
                    if (tick_sum >= {1'b0, period}) begin
                        tick_sum     = tick_sum - {1'b0, period};
                        n_burst_left = BURST_LOAD;
                    end
                    n_period_timer = tick_sum[PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_div     <= irbbm_pkg::SLOW_DIV_RESET;
            r_burst_left   <= '0;
            r_loss_pending <= 1'b0;
            r_period_timer <= '0;
            r_beep_left    <= '0;
            r_loss_counter <= '0;
            r_drive_level  <= 1'b0;
            r_beep_level   <= 1'b0;
            r_led_level    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slow_div <= i_cfg_data;
            end
            r_burst_left   <= n_burst_left;
            r_loss_pending <= n_loss_pending;
            r_period_timer <= n_period_timer;
            r_beep_left    <= n_beep_left;
            r_loss_counter <= n_loss_counter;
            r_drive_level  <= n_drive_level;
            r_beep_level   <= n_beep_level;
            r_led_level    <= n_led_level;
        end
    end

    assign o_result.ir_drive      = n_drive_level;
    assign o_result.beep_out      = n_beep_level;
    assign o_result.cal_indicator = n_led_level;
    assign o_result.loss_count    = n_loss_counter;

    `include "ir_barrier_burst_monitor_assert.svh"

    `IRBBM_ASSERT_NXT(a_burst_step, i_clk, i_rst_n,
        i_accept && i_item.operation == irbbm_pkg::OP_CARRIER && r_burst_left != '0,
        r_burst_left == $past(r_burst_left) - BW'(1), "burst count did not step down")
    `IRBBM_ASSERT_NXT(a_loss_count, i_clk, i_rst_n,
        i_accept && i_item.operation == irbbm_pkg::OP_HOUSE && r_loss_pending,
        !r_loss_pending && r_loss_counter == $past(r_loss_counter) + CW'(1),
        "pending loss not counted")
    `IRBBM_ASSERT_NXT(a_carrier_quiet, i_clk, i_rst_n,
        i_accept && i_item.operation == irbbm_pkg::OP_CARRIER,
        $stable(r_led_level) && $stable(r_beep_level) && $stable(r_loss_counter),
        "carrier beat changed housekeeping state")

endmodule

`default_nettype wire

[src/ir_barrier_burst_monitor.sv]
// ----------------------------------------------------------------------------
// ir_barrier_burst_monitor
// infrared light-barrier pulser and beam-loss detector
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
//   tick: a carrier tick or a housekeeping tick with mode, calibrate switch
//   and receiver level.
//   output channel (o_out_valid / i_out_ready / o_out_data) gives exactly one
//   beat per input beat: emitter drive, buzzer, calibrate led, loss count.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the slow
//   divider; it is always ready and should be written while the block idles.
//   result: registered, valid in the cycle after its input beat is taken.
//   throughput: one beat per cycle while the output is taken, set by the
//   single state update between input handshake and output register.
//   stall: when the receiver holds off, the output register keeps its beat
//   and the input stays ready only in the cycle the output is taken.
//   reset: synchronous, active low; all state but the output data register
//   clears, slow divider goes to 64, no output is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_barrier_burst_monitor #(
    parameter int unsigned BURST_PULSES = irbbm_pkg::BURST_PULSES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  irbbm_pkg::t_in_item              i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output irbbm_pkg::t_out_item             o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [irbbm_pkg::PERIOD_W-1:0]    i_cfg_data
);

    logic                 in_accept;
    irbbm_pkg::t_out_item result;
    logic                 r_out_valid;
    irbbm_pkg::t_out_item r_out_data;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    irbbm_core #(
        .BURST_PULSES (BURST_PULSES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
